// ===== src/stq_pkg.sv =====
package stq_pkg;

    localparam int NUM_TIMERS_DEF   = 32;
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int ID_W             = 6;
    localparam int CH_W             = 4;
    localparam int DATA_W           = 32;

    localparam logic [DATA_W-1:0] NEVER = '1;

    localparam logic [1:0] ADDR_TASK_SW = 2'd0;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_ALLOCATE   = 3'd1;
    localparam logic [2:0] OP_FREE       = 3'd2;
    localparam logic [2:0] OP_INIT       = 3'd3;
    localparam logic [2:0] OP_SET        = 3'd4;
    localparam logic [2:0] OP_CANCEL     = 3'd5;
    localparam logic [2:0] OP_CANCEL_ALL = 3'd6;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRY  = 2'd1;
    localparam logic [1:0] KIND_TASK_SW = 2'd2;

    localparam logic [1:0] CMD_NOP    = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_POP    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] deadline;
    } cmd_t;

endpackage

// ===== src/stq_cell.sv =====
module stq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  stq_pkg::cmd_t   cmd,
    input  stq_pkg::entry_t prev_entry,
    input  stq_pkg::entry_t next_entry,
    input  logic            prev_after,
    input  logic            prev_past,
    output stq_pkg::entry_t entry,
    output logic            after,
    output logic            past
);

    stq_pkg::entry_t entry_reg;
    stq_pkg::entry_t entry_next;
    stq_pkg::entry_t new_entry;

    assign after = entry_reg.valid && (entry_reg.deadline < cmd.deadline);
    assign past  = prev_past || (entry_reg.valid && (entry_reg.id == cmd.id));
    assign entry = entry_reg;

    always_comb
    begin
        new_entry.valid    = 1'b1;
        new_entry.id       = cmd.id;
        new_entry.deadline = cmd.deadline;
        entry_next = entry_reg;
        case (cmd.op)
            stq_pkg::CMD_INSERT:
            begin
                if (!after)
                begin
                    entry_next = prev_after ? new_entry : prev_entry;
                end
            end
            stq_pkg::CMD_REMOVE:
            begin
                if (past)
                begin
                    entry_next = next_entry;
                end
            end
            stq_pkg::CMD_POP:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== src/stq_chain.sv =====
module stq_chain #(
    parameter int NUM_CELLS = stq_pkg::NUM_TIMERS_DEF - 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  stq_pkg::cmd_t   cmd,
    output stq_pkg::entry_t head0,
    output stq_pkg::entry_t head1
);

    stq_pkg::entry_t entries [NUM_CELLS];
    logic            afters  [NUM_CELLS];
    logic            pasts   [NUM_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            stq_pkg::entry_t prev_e;
            stq_pkg::entry_t next_e;
            logic            prev_a;
            logic            prev_p;
            if (gi == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_a = 1'b1;
                assign prev_p = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = entries[gi-1];
                assign prev_a = afters[gi-1];
                assign prev_p = pasts[gi-1];
            end
            if (gi == NUM_CELLS - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = entries[gi+1];
            end
            stq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .prev_after (prev_a),
                .prev_past  (prev_p),
                .entry      (entries[gi]),
                .after      (afters[gi]),
                .past       (pasts[gi])
            );
        end
        if (NUM_CELLS > 1)
        begin : g_h1
            assign head1 = entries[1];
        end
        else
        begin : g_h1_none
            assign head1 = '0;
        end
    endgenerate

    assign head0 = entries[0];

endmodule

// ===== src/sorted_software_timer_queue_core.sv =====
// Sorted timer queue. Running timers sit in a chain of cells in ascending deadline
// order, a new timer going before any with an equal deadline; the never-expiring
// sentinel of slot 0 is implied at the chain's end. For every operation other than tick
// the acknowledge is offered from the output register in the cycle after it is taken;
// a set of a running timer then holds the input while the chain inserts it anew, and a
// cancel-all of a valid channel holds it while it sweeps slots 1 to NUM_TIMERS - 1
// one per cycle. A tick holds the input while the expired timers are popped, each
// delivery leaving in deadline order as the chain pops its head, the task-switch
// result last; a stalled output holds it longer. Items are taken only while no
// earlier item is in progress and the output register is free or being drained.
module sorted_software_timer_queue_core #(
    parameter int NUM_TIMERS   = stq_pkg::NUM_TIMERS_DEF,
    parameter int NUM_CHANNELS = stq_pkg::NUM_CHANNELS_DEF,
    parameter int SlotW        = $clog2(NUM_TIMERS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 opcode,
    input  logic [SlotW-1:0]           slot,
    input  logic [stq_pkg::CH_W-1:0]   channel,
    input  logic [stq_pkg::DATA_W-1:0] payload,
    input  logic [stq_pkg::DATA_W-1:0] delay,
    input  logic                       auto_cancel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [SlotW-1:0]           out_slot,
    output logic [stq_pkg::CH_W-1:0]   out_channel,
    output logic [stq_pkg::DATA_W-1:0] out_payload,
    output logic                       ok,
    output logic                       last
);

    localparam int NW = $clog2(stq_pkg::MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;

    logic [2:0]                 state_reg, state_next;
    logic [31:0]                count_reg, count_next;
    logic [SlotW-1:0]           tsk_reg, tsk_next;
    logic [NW-1:0]              n_reg, n_next;
    logic                       ts_reg, ts_next;
    logic [SlotW-1:0]           sweep_idx_reg, sweep_idx_next;
    logic [stq_pkg::CH_W-1:0]   sweep_ch_reg, sweep_ch_next;
    logic [31:0]                pend_dl_reg, pend_dl_next;
    logic [SlotW-1:0]           pend_id_reg, pend_id_next;
    logic [NUM_TIMERS-1:0]      alloc_reg, alloc_next;
    logic [NUM_TIMERS-1:0]      run_reg, run_next;
    logic [NUM_TIMERS-1:0]      mark_reg, mark_next;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [SlotW-1:0]           out_slot_reg, out_slot_next;
    logic [stq_pkg::CH_W-1:0]   out_ch_reg, out_ch_next;
    logic [31:0]                out_pay_reg, out_pay_next;
    logic                       ok_reg, ok_next;
    logic                       last_reg, last_next;

    logic [stq_pkg::CH_W-1:0]   chan_mem [NUM_TIMERS];
    logic [31:0]                pay_mem  [NUM_TIMERS];
    logic                       wr_en;

    logic [NUM_TIMERS-1:0]      sweep_hit;
    logic [SlotW-1:0]           free_slot;
    logic                       free_found;
    logic                       out_free;
    logic                       accept;
    logic                       slot_ok;
    logic                       ch_ok;
    logic [32:0]                dl_sum;
    logic [31:0]                dl_sat;
    logic [SlotW-1:0]           h0_id;
    logic                       exp0, exp1;
    logic [NW:0]                used;

    stq_pkg::cmd_t              cmd;
    stq_pkg::entry_t            head0, head1;

    stq_chain #(
        .NUM_CELLS (NUM_TIMERS - 1)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head0 (head0),
        .head1 (head1)
    );

    assign pready      = 1'b1;
    assign prdata      = {{(32 - SlotW){1'b0}}, tsk_reg};
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_slot    = out_slot_reg;
    assign out_channel = out_ch_reg;
    assign out_payload = out_pay_reg;
    assign ok          = ok_reg;
    assign last        = last_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign slot_ok  = (slot != '0) && (int'(slot) < NUM_TIMERS);
    assign ch_ok    = int'(channel) < NUM_CHANNELS;
    assign wr_en    = accept && (opcode == stq_pkg::OP_INIT) && slot_ok && alloc_reg[slot]
                      && ch_ok;
    assign dl_sum   = {1'b0, count_reg} + {1'b0, delay};
    assign dl_sat   = dl_sum[32] ? stq_pkg::NEVER : dl_sum[31:0];
    assign h0_id    = head0.id[SlotW-1:0];
    assign used     = {1'b0, n_reg} + {{NW{1'b0}}, ts_reg};
    assign exp0     = head0.valid && (count_reg >= head0.deadline)
                      && (used < (NW+1)'(stq_pkg::MAX_RESULTS));
    assign exp1     = head1.valid && (count_reg >= head1.deadline)
                      && ((used + 1'b1) < (NW+1)'(stq_pkg::MAX_RESULTS));

    always_comb
    begin
        sweep_hit = '0;
        for (int i = 1; i < NUM_TIMERS; i++)
        begin
            sweep_hit[i] = alloc_reg[i] && mark_reg[i] && (chan_mem[i] == sweep_ch_reg);
        end
    end

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 1; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_slot  = SlotW'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tsk_next       = tsk_reg;
        n_next         = n_reg;
        ts_next        = ts_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_ch_next  = sweep_ch_reg;
        pend_dl_next   = pend_dl_reg;
        pend_id_next   = pend_id_reg;
        alloc_next     = alloc_reg;
        run_next       = run_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        out_slot_next  = out_slot_reg;
        out_ch_next    = out_ch_reg;
        out_pay_next   = out_pay_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        cmd.op         = stq_pkg::CMD_NOP;
        cmd.id         = {{(stq_pkg::ID_W - SlotW){1'b0}}, slot};
        cmd.deadline   = dl_sat;

        if (psel && penable && pwrite && (paddr == stq_pkg::ADDR_TASK_SW))
        begin
            tsk_next = pwdata[SlotW-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = stq_pkg::KIND_ACK;
                    out_slot_next  = '0;
                    out_ch_next    = '0;
                    out_pay_next   = '0;
                    ok_next        = 1'b0;
                    last_next      = 1'b1;
                    case (opcode)
                        stq_pkg::OP_TICK:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                            count_next     = count_reg + 32'd1;
                            n_next         = '0;
                            ts_next        = 1'b0;
                            state_next     = S_TICK;
                        end
                        stq_pkg::OP_ALLOCATE:
                        begin
                            if (free_found)
                            begin
                                alloc_next[free_slot] = 1'b1;
                                mark_next[free_slot]  = 1'b0;
                                out_slot_next         = free_slot;
                                ok_next               = 1'b1;
                            end
                        end
                        stq_pkg::OP_FREE:
                        begin
                            if (slot_ok)
                            begin
                                if (run_reg[slot])
                                begin
                                    cmd.op = stq_pkg::CMD_REMOVE;
                                end
                                run_next[slot]   = 1'b0;
                                alloc_next[slot] = 1'b0;
                                mark_next[slot]  = 1'b0;
                            end
                        end
                        stq_pkg::OP_INIT:
                        begin
                            if (wr_en)
                            begin
                                mark_next[slot] = auto_cancel;
                            end
                        end
                        stq_pkg::OP_SET:
                        begin
                            if (slot_ok && alloc_reg[slot])
                            begin
                                run_next[slot] = 1'b1;
                                if (run_reg[slot])
                                begin
                                    cmd.op       = stq_pkg::CMD_REMOVE;
                                    pend_dl_next = dl_sat;
                                    pend_id_next = slot;
                                    state_next   = S_INSERT;
                                end
                                else
                                begin
                                    cmd.op = stq_pkg::CMD_INSERT;
                                end
                            end
                        end
                        stq_pkg::OP_CANCEL:
                        begin
                            if (slot_ok && run_reg[slot])
                            begin
                                cmd.op         = stq_pkg::CMD_REMOVE;
                                run_next[slot] = 1'b0;
                                ok_next        = 1'b1;
                            end
                        end
                        stq_pkg::OP_CANCEL_ALL:
                        begin
                            if (ch_ok)
                            begin
                                sweep_ch_next  = channel;
                                sweep_idx_next = SlotW'(1);
                                state_next     = S_SWEEP;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                cmd.op       = stq_pkg::CMD_INSERT;
                cmd.id       = {{(stq_pkg::ID_W - SlotW){1'b0}}, pend_id_reg};
                cmd.deadline = pend_dl_reg;
                state_next   = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.id = {{(stq_pkg::ID_W - SlotW){1'b0}}, sweep_idx_reg};
                if (sweep_hit[sweep_idx_reg])
                begin
                    if (run_reg[sweep_idx_reg])
                    begin
                        cmd.op = stq_pkg::CMD_REMOVE;
                    end
                    run_next[sweep_idx_reg]   = 1'b0;
                    alloc_next[sweep_idx_reg] = 1'b0;
                    mark_next[sweep_idx_reg]  = 1'b0;
                end
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == SlotW'(NUM_TIMERS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    if (exp0)
                    begin
                        cmd.op          = stq_pkg::CMD_POP;
                        run_next[h0_id] = 1'b0;
                        if (h0_id == tsk_reg)
                        begin
                            ts_next = 1'b1;
                        end
                        else
                        begin
                            n_next         = n_reg + 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = stq_pkg::KIND_EXPIRY;
                            out_slot_next  = h0_id;
                            out_ch_next    = chan_mem[h0_id];
                            out_pay_next   = pay_mem[h0_id];
                            ok_next        = 1'b0;
                            last_next      = !exp1 && !ts_reg;
                        end
                    end
                    else
                    begin
                        if (ts_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = stq_pkg::KIND_TASK_SW;
                            out_slot_next  = tsk_reg;
                            out_ch_next    = '0;
                            out_pay_next   = '0;
                            ok_next        = 1'b0;
                            last_next      = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chan_mem[slot] <= channel;
            pay_mem[slot]  <= payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tsk_reg       <= '0;
            n_reg         <= '0;
            ts_reg        <= 1'b0;
            sweep_idx_reg <= '0;
            alloc_reg     <= {{(NUM_TIMERS - 1){1'b0}}, 1'b1};
            run_reg       <= {{(NUM_TIMERS - 1){1'b0}}, 1'b1};
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tsk_reg       <= tsk_next;
            n_reg         <= n_next;
            ts_reg        <= ts_next;
            sweep_idx_reg <= sweep_idx_next;
            alloc_reg     <= alloc_next;
            run_reg       <= run_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_ch_reg <= sweep_ch_next;
        pend_dl_reg  <= pend_dl_next;
        pend_id_reg  <= pend_id_next;
        kind_reg     <= kind_next;
        out_slot_reg <= out_slot_next;
        out_ch_reg   <= out_ch_next;
        out_pay_reg  <= out_pay_next;
        ok_reg       <= ok_next;
        last_reg     <= last_next;
    end

    a_head_running: assert property (@(posedge clk) disable iff (!rst_n)
        head0.valid |-> run_reg[h0_id])
        else $error("chain head is not marked running");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        head0.valid && head1.valid |-> head0.deadline <= head1.deadline)
        else $error("chain head out of deadline order");

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == stq_pkg::KIND_ACK) |-> last_reg)
        else $error("acknowledge not marked last");

    a_task_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == stq_pkg::KIND_TASK_SW) |-> last_reg && !ok_reg)
        else $error("task switch result not last");

endmodule
